// ===== rtl/lwkd_pkg.sv =====
// Shared types and constants for the longest k-distinct window block.
// No dependencies; lwkd_cnt_tbl and longest_window_k_distinct import this package.
package lwkd_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_LEN_DEF  = 4096;
    localparam int ALPHABET_DEF = 256;

    // Fixed field widths on the ports
    localparam int SYM_IN_W  = 8;
    localparam int CFG_W     = 9;
    localparam int LEN_OUT_W = 13;

    localparam logic [CFG_W-1:0] K_RESET = 9'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for a word
        ST_ADD,     // bump count of the new byte
        ST_EV_H,    // fetch oldest byte from history
        ST_EV_C,    // fetch its count
        ST_EV_W,    // decrement it, advance window start
        ST_FIN      // window length, best update, result out
    } t_state;

    // Count table command
    typedef struct packed {
        logic rd;   // read request, data next cycle
        logic wr;   // write request
        logic clr;  // forget every entry (back to zero)
    } t_cnt_ctl;

endpackage

// ===== rtl/lwkd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lwkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lwkd_cnt_tbl.sv =====
// Per-value count table: RAM plus one valid bit per entry, so a clear drops all valid bits together.
// Depends on lwkd_pkg and lwkd_ram.
module lwkd_cnt_tbl #(
    parameter int ALPHABET = lwkd_pkg::ALPHABET_DEF,
    parameter int CNT_W    = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lwkd_pkg::t_cnt_ctl          i_ctl,
    input  logic [$clog2(ALPHABET)-1:0] i_rd_addr,
    input  logic [$clog2(ALPHABET)-1:0] i_wr_addr,
    input  logic [CNT_W-1:0]            i_wr_data,
    output logic [CNT_W-1:0]            o_rd_data
);
    import lwkd_pkg::*;

    logic [ALPHABET-1:0] r_valid;
    logic                r_rd_vld;
    logic [CNT_W-1:0]    ram_q;

    lwkd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ALPHABET)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_ctl.rd),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // Valid bits: set on write, all dropped on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Valid flag follows the registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    // Never-written entry reads as zero
    assign o_rd_data = r_rd_vld ? ram_q : '0;

endmodule

// ===== rtl/longest_window_k_distinct.sv =====
// Longest window with at most K distinct byte values over a byte stream.
// Depends on lwkd_pkg, lwkd_ram (history) and lwkd_cnt_tbl (per-value counts).
//
// Usage:
//   Bytes of a string arrive on the s_axis word channel, tlast on the final
//   byte. Each accepted word gives exactly one result word on m_axis: the
//   longest window so far in this string, tlast copied from the input and
//   tuser set once the string has gone past MAX_LEN bytes (later bytes are
//   dropped and repeat the last length).
//   User must write limit K via cfg channel (always ready) only while idle; not enforced.
// Steps:
//   A kept byte passes accept, count update and length/result, plus history
//   read, count read and count write for every byte that leaves the window
//   start; a dropped byte passes accept and result. Each byte leaves at most
//   once. The registered reads of the history and count RAMs set these steps.
//   Result appears in the output register on the cycle after the final step.
// Reset and stall:
//   Reset empties the string state and sets K to 2; count entries are wiped
//   through their valid bits, so there is no clearing pass. The next word
//   is taken while a result is held; a stalled m_axis only holds the block
//   in its final step until the output register frees.
module longest_window_k_distinct #(
    parameter int MAX_LEN  = lwkd_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = lwkd_pkg::ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write: max_distinct
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lwkd_pkg::CFG_W-1:0]    i_cfg_data,
    // Input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] symbol
    input  logic                          s_axis_tlast,   // last_symbol
    // Result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [12:0] longest_so_far, rest zero
    output logic                          m_axis_tlast,   // end_of_string
    output logic                          m_axis_tuser    // [0] overflow
);
    import lwkd_pkg::*;

    localparam int AW    = $clog2(MAX_LEN);
    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int SYM_W = $clog2(ALPHABET);
    localparam int DW    = $clog2(ALPHABET + 1);

    // Control and string state
    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_k;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_begin, n_begin;
    logic [POS_W-1:0]  r_best, n_best;
    logic [DW-1:0]     r_dist, n_dist;
    logic              r_ovf, n_ovf;
    logic              r_out_vld, n_out_vld;
    // Per-word payload
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [SYM_W-1:0]  r_old, n_old;
    logic              r_last, n_last;
    logic              r_skip, n_skip;
    logic [LEN_OUT_W-1:0] r_out_len, n_out_len;
    logic              r_out_last, n_out_last;
    logic              r_out_ovf, n_out_ovf;

    // Memory ports
    logic              hist_wr_en, hist_rd_en;
    logic [SYM_W-1:0]  hist_q;
    t_cnt_ctl          cnt_ctl;
    logic [SYM_W-1:0]  cnt_rd_addr, cnt_wr_addr;
    logic [POS_W-1:0]  cnt_wr_data, cnt_q;

    // Datapath helpers
    logic [SYM_W-1:0]  sym_tbl [256];
    logic [SYM_W-1:0]  sym_in;
    logic [DW-1:0]     dist_add, dist_dec;
    logic [POS_W-1:0]  len, best_new;
    logic              out_free;

    // Constant lookup: byte value reduced to the alphabet
    for (genvar g = 0; g < 256; g++) begin : g_sym_tbl
        assign sym_tbl[g] = SYM_W'(g % ALPHABET);
    end

    assign sym_in   = sym_tbl[s_axis_tdata];
    assign dist_add = (cnt_q == '0) ? r_dist + DW'(1) : r_dist;
    assign dist_dec = (cnt_q == POS_W'(1)) ? r_dist - DW'(1) : r_dist;
    assign len      = r_pos + POS_W'(1) - r_begin;
    assign best_new = (len > r_best) ? len : r_best;
    assign out_free = !r_out_vld || m_axis_tready;

    lwkd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (r_pos[AW-1:0]),
        .i_wr_data (sym_in),
        .i_rd_en   (hist_rd_en),
        .i_rd_addr (r_begin[AW-1:0]),
        .o_rd_data (hist_q)
    );

    lwkd_cnt_tbl #(
        .ALPHABET (ALPHABET),
        .CNT_W    (POS_W)
    ) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cnt_ctl),
        .i_rd_addr (cnt_rd_addr),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .o_rd_data (cnt_q)
    );

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= K_RESET;
            r_pos     <= '0;
            r_begin   <= '0;
            r_best    <= '0;
            r_dist    <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_begin   <= n_begin;
            r_best    <= n_best;
            r_dist    <= n_dist;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_k <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_old      <= n_old;
        r_last     <= n_last;
        r_skip     <= n_skip;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // Sequencer: next state and memory commands
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_begin     = r_begin;
        n_best      = r_best;
        n_dist      = r_dist;
        n_ovf       = r_ovf;
        n_sym       = r_sym;
        n_old       = r_old;
        n_last      = r_last;
        n_skip      = r_skip;
        n_out_len   = r_out_len;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_out_vld   = r_out_vld && !m_axis_tready;
        hist_wr_en  = 1'b0;
        hist_rd_en  = 1'b0;
        cnt_ctl     = '0;
        cnt_rd_addr = r_old;
        cnt_wr_addr = r_sym;
        cnt_wr_data = '0;

        case (r_state)
            ST_IDLE: begin
                cnt_rd_addr = sym_in;
                if (s_axis_tvalid) begin
                    n_sym  = sym_in;
                    n_last = s_axis_tlast;
                    if (r_pos >= POS_W'(MAX_LEN)) begin
                        // string too long: byte dropped
                        n_ovf   = 1'b1;
                        n_skip  = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_skip     = 1'b0;
                        hist_wr_en = 1'b1;
                        cnt_ctl.rd = 1'b1;
                        n_state    = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                cnt_ctl.wr  = 1'b1;
                cnt_wr_addr = r_sym;
                cnt_wr_data = cnt_q + POS_W'(1);
                n_dist      = dist_add;
                if (CFG_W'(dist_add) > r_k && r_begin <= r_pos) begin
                    n_state = ST_EV_H;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_EV_H: begin
                hist_rd_en = 1'b1;
                n_state    = ST_EV_C;
            end
            ST_EV_C: begin
                cnt_ctl.rd  = 1'b1;
                cnt_rd_addr = hist_q;
                n_old       = hist_q;
                n_state     = ST_EV_W;
            end
            ST_EV_W: begin
                cnt_wr_addr = r_old;
                cnt_wr_data = cnt_q - POS_W'(1);
                if (cnt_q != '0) begin
                    cnt_ctl.wr = 1'b1;
                    n_dist     = dist_dec;
                end
                n_begin = r_begin + POS_W'(1);
                if (cnt_q != '0 && CFG_W'(dist_dec) > r_k && n_begin <= r_pos) begin
                    n_state = ST_EV_H;
                end else if (cnt_q == '0 && CFG_W'(r_dist) > r_k && n_begin <= r_pos) begin
                    n_state = ST_EV_H;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_last = r_last;
                    n_out_ovf  = r_ovf;
                    if (r_skip) begin
                        n_out_len = LEN_OUT_W'(r_best);
                    end else begin
                        n_out_len = LEN_OUT_W'(best_new);
                        n_best    = best_new;
                        n_pos     = r_pos + POS_W'(1);
                    end
                    // end of string: fresh window for the next one
                    if (r_last) begin
                        n_pos       = '0;
                        n_begin     = '0;
                        n_best      = '0;
                        n_dist      = '0;
                        n_ovf       = 1'b0;
                        cnt_ctl.clr = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(16 - LEN_OUT_W){1'b0}}, r_out_len};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

endmodule
